// ===== rtl/core/rfgm_pkg.sv =====
// Package for the reduced fraction gain multiplier.
// Holds value widths, status codes, unit opcodes, state types and the unit request/response structs.
// No dependencies.
package rfgm_pkg;

	// Width of every value field.
	localparam int VW = 64;
	// Width of a bit-length result, wide enough to hold VW itself.
	localparam int LW = $clog2(VW + 1);
	// Width of the bit-length bound outputs.
	localparam int BW = 8;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_CONTEXT  = 2'd2,
		ST_CAPACITY = 2'd3
	} status_t;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		OP_GCD = 2'd0,
		OP_DIV = 2'd1,
		OP_MUL = 2'd2
	} alu_op_t;

	// Shared unit states.
	typedef enum logic [1:0] {
		U_IDLE,
		U_RUN,
		U_SHIFT
	} unit_state_t;

	// Sequencer states, one for each operation of the flow.
	typedef enum logic [3:0] {
		S_IDLE,
		S_G1,
		S_D1A,
		S_D1B,
		S_G2,
		S_D2A,
		S_D2B,
		S_M1,
		S_M2,
		S_G3,
		S_D3A,
		S_D3B
	} seq_state_t;

	// Request from the sequencer to the shared unit.
	typedef struct packed {
		logic          start;
		alu_op_t       op;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} alu_req_t;

	// Response from the shared unit, valid while done is high.
	typedef struct packed {
		logic          done;
		logic [VW-1:0] lo;
		logic [VW-1:0] hi;
		logic [LW-1:0] len;
	} alu_rsp_t;

endpackage

// ===== rtl/core/rfgm_unit.sv =====
// Shared iterative arithmetic unit: binary gcd, restoring division and shift-add multiply.
// One step per clock; the quotient bit length is tracked during division.
// Depends on rfgm_pkg.
module rfgm_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  rfgm_pkg::alu_req_t req,
	output rfgm_pkg::alu_rsp_t rsp
);
	import rfgm_pkg::*;

	unit_state_t   state_q, state_d;
	alu_op_t       op_q, op_d;
	logic [VW-1:0] x_q, x_d;
	logic [VW-1:0] y_q, y_d;
	logic [VW-1:0] z_q, z_d;
	logic [LW-1:0] cnt_q, cnt_d;
	logic [LW-1:0] len_q, len_d;
	logic          done_q, done_d;

	logic [VW:0]   sub_xy;
	logic [VW:0]   sub_yx;
	logic [VW:0]   div_sh;
	logic [VW+1:0] div_diff;
	logic          div_ge;
	logic [VW:0]   mul_sum;

	// Datapath: two compare-subtracts for gcd, one for division, one adder for multiply.
	always_comb begin
		sub_xy   = {1'b0, x_q} - {1'b0, y_q};
		sub_yx   = {1'b0, y_q} - {1'b0, x_q};
		div_sh   = {z_q, x_q[VW-1]};
		div_diff = {1'b0, div_sh} - {2'b00, y_q};
		div_ge   = !div_diff[VW+1];
		mul_sum  = {1'b0, z_q} + (x_q[0] ? {1'b0, y_q} : {(VW+1){1'b0}});
	end

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Operand and counter registers.
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		x_q   <= x_d;
		y_q   <= y_d;
		z_q   <= z_d;
		cnt_q <= cnt_d;
		len_q <= len_d;
	end

	// Next state and one step of the selected operation.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		x_d     = x_q;
		y_d     = y_q;
		z_d     = z_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		done_d  = 1'b0;
		unique case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_d    = req.op;
					x_d     = req.a;
					y_d     = req.b;
					z_d     = '0;
					cnt_d   = '0;
					len_d   = '0;
					state_d = U_RUN;
				end
			end
			U_RUN: begin
				unique case (op_q)
					OP_GCD: begin
						// Stein's algorithm; cnt counts the common factors of two.
						priority if (x_q == '0) begin
							if (cnt_q == '0) begin
								state_d = U_IDLE;
								done_d  = 1'b1;
							end else begin
								state_d = U_SHIFT;
							end
						end else if (!x_q[0] && !y_q[0]) begin
							x_d   = x_q >> 1;
							y_d   = y_q >> 1;
							cnt_d = cnt_q + 1'b1;
						end else if (!x_q[0]) begin
							x_d = x_q >> 1;
						end else if (!y_q[0]) begin
							y_d = y_q >> 1;
						end else if (!sub_xy[VW]) begin
							x_d = {1'b0, sub_xy[VW-1:1]};
						end else begin
							y_d = {1'b0, sub_yx[VW-1:1]};
						end
					end
					OP_DIV: begin
						// Restoring division, quotient shifts into x from the right.
						z_d = div_ge ? div_diff[VW-1:0] : div_sh[VW-1:0];
						x_d = {x_q[VW-2:0], div_ge};
						if (div_ge && len_q == '0) begin
							len_d = LW'(VW) - cnt_q;
						end
						cnt_d = cnt_q + 1'b1;
						if (cnt_q == LW'(VW - 1)) begin
							state_d = U_IDLE;
							done_d  = 1'b1;
						end
					end
					OP_MUL: begin
						// Shift-add multiply: high half in z, low half shifts into x.
						z_d   = mul_sum[VW:1];
						x_d   = {mul_sum[0], x_q[VW-1:1]};
						cnt_d = cnt_q + 1'b1;
						if (cnt_q == LW'(VW - 1)) begin
							state_d = U_IDLE;
							done_d  = 1'b1;
						end
					end
					default: begin
						state_d = U_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end
			U_SHIFT: begin
				// Restore the common power of two on the gcd.
				y_d   = y_q << 1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == LW'(1)) begin
					state_d = U_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = U_IDLE;
			end
		endcase
	end

	// Results stay stable in the registers until the next operation starts.
	always_comb begin
		rsp.done = done_q;
		rsp.lo   = (op_q == OP_GCD) ? y_q : x_q;
		rsp.hi   = z_q;
		rsp.len  = len_q;
	end

endmodule

// ===== rtl/core/reduced_fraction_gain_multiply.sv =====
// Top level of the reduced fraction gain multiplier: sequencer and result registers.
// Instantiates rfgm_unit; depends on rfgm_pkg.
//
// Usage: a transfer of one item is taken at a rising edge where start is high and busy is
// low; the four 64-bit values and contexts_match are sampled at that edge. Exactly one
// result follows: done is high for one cycle while status, prod_num, prod_den,
// num_bits_bound and den_bits_bound hold it, and the result transfer completes at the end
// of that cycle. The receiver cannot stall; done is not held, the values stay until the next result.
// An invalid operand or a context mismatch is reported in the cycle after the start.
// Otherwise the block runs gcd, two divisions, gcd, two divisions, two multiplies, gcd and
// two divisions on one shared unit, one step per cycle. A product overflow ends the item
// after the first or second multiply, and a product pair that is not a gain strictly
// between zero and one ends it with ST_INVALID after the second. busy is high for the
// whole of the item and falls in the cycle in which done is high, so the next start can
// be taken then.
// Reset: arst_n clears the sequencer and the done strobe; no result is pending after it.
module reduced_fraction_gain_multiply (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rfgm_pkg::VW-1:0]    left_num,
	input  logic [rfgm_pkg::VW-1:0]    left_den,
	input  logic [rfgm_pkg::VW-1:0]    right_num,
	input  logic [rfgm_pkg::VW-1:0]    right_den,
	input  logic                       contexts_match,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [rfgm_pkg::VW-1:0]    prod_num,
	output logic [rfgm_pkg::VW-1:0]    prod_den,
	output logic [rfgm_pkg::BW-1:0]    num_bits_bound,
	output logic [rfgm_pkg::BW-1:0]    den_bits_bound
);
	import rfgm_pkg::*;

	seq_state_t    state_q, state_d;
	logic [VW-1:0] ln_q, ln_d;
	logic [VW-1:0] ld_q, ld_d;
	logic [VW-1:0] rn_q, rn_d;
	logic [VW-1:0] rd_q, rd_d;
	logic [VW-1:0] g_q, g_d;
	logic [VW-1:0] pn_q, pn_d;
	logic [VW-1:0] pd_q, pd_d;
	logic [BW-1:0] nb_q, nb_d;
	logic [BW-1:0] db_q, db_d;

	logic          done_q;
	status_t       status_q;
	logic [VW-1:0] onum_q;
	logic [VW-1:0] oden_q;
	logic [BW-1:0] onb_q;
	logic [BW-1:0] odb_q;

	logic          emit;
	status_t       emit_status;
	logic [VW-1:0] emit_num;
	logic [VW-1:0] emit_den;
	logic [BW-1:0] emit_nb;
	logic [BW-1:0] emit_db;

	logic          left_ok;
	logic          right_ok;
	logic [BW-1:0] len_ext;

	alu_req_t      req;
	alu_rsp_t      rsp;

	rfgm_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Operand checks: each gain must lie strictly between zero and one.
	always_comb begin
		left_ok  = (left_den != '0) && (left_num != '0) && (left_num < left_den);
		right_ok = (right_den != '0) && (right_num != '0) && (right_num < right_den);
		len_ext  = BW'(rsp.len);
	end

	// Sequencer state and strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	// Working values and result registers.
	always_ff @(posedge clk) begin
		ln_q <= ln_d;
		ld_q <= ld_d;
		rn_q <= rn_d;
		rd_q <= rd_d;
		g_q  <= g_d;
		pn_q <= pn_d;
		pd_q <= pd_d;
		nb_q <= nb_d;
		db_q <= db_d;
		if (emit) begin
			status_q <= emit_status;
			onum_q   <= emit_num;
			oden_q   <= emit_den;
			onb_q    <= emit_nb;
			odb_q    <= emit_db;
		end
	end

	// Next state: each finished unit operation stores its result and launches the next one or ends the item with a result.
	always_comb begin
		state_d     = state_q;
		ln_d        = ln_q;
		ld_d        = ld_q;
		rn_d        = rn_q;
		rd_d        = rd_q;
		g_d         = g_q;
		pn_d        = pn_q;
		pd_d        = pd_q;
		nb_d        = nb_q;
		db_d        = db_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_num    = '0;
		emit_den    = '0;
		emit_nb     = '0;
		emit_db     = '0;
		req.start   = 1'b0;
		req.op      = OP_GCD;
		req.a       = '0;
		req.b       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ln_d = left_num;
					ld_d = left_den;
					rn_d = right_num;
					rd_d = right_den;
					priority if (!left_ok || !right_ok) begin
						emit        = 1'b1;
						emit_status = ST_INVALID;
					end else if (!contexts_match) begin
						emit        = 1'b1;
						emit_status = ST_CONTEXT;
					end else begin
						req.start = 1'b1;
						req.op    = OP_GCD;
						req.a     = left_num;
						req.b     = right_den;
						state_d   = S_G1;
					end
				end
			end
			S_G1: begin
				if (rsp.done) begin
					g_d       = rsp.lo;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = ln_q;
					req.b     = rsp.lo;
					state_d   = S_D1A;
				end
			end
			S_D1A: begin
				if (rsp.done) begin
					ln_d      = rsp.lo;
					nb_d      = len_ext;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = rd_q;
					req.b     = g_q;
					state_d   = S_D1B;
				end
			end
			S_D1B: begin
				if (rsp.done) begin
					rd_d      = rsp.lo;
					db_d      = len_ext;
					req.start = 1'b1;
					req.op    = OP_GCD;
					req.a     = rn_q;
					req.b     = ld_q;
					state_d   = S_G2;
				end
			end
			S_G2: begin
				if (rsp.done) begin
					g_d       = rsp.lo;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = rn_q;
					req.b     = rsp.lo;
					state_d   = S_D2A;
				end
			end
			S_D2A: begin
				if (rsp.done) begin
					rn_d      = rsp.lo;
					nb_d      = nb_q + len_ext;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = ld_q;
					req.b     = g_q;
					state_d   = S_D2B;
				end
			end
			S_D2B: begin
				if (rsp.done) begin
					ld_d      = rsp.lo;
					db_d      = db_q + len_ext;
					req.start = 1'b1;
					req.op    = OP_MUL;
					req.a     = ln_q;
					req.b     = rn_q;
					state_d   = S_M1;
				end
			end
			S_M1: begin
				// A nonzero high half means the numerator product overflows.
				if (rsp.done) begin
					if (rsp.hi != '0) begin
						emit        = 1'b1;
						emit_status = ST_CAPACITY;
						emit_nb     = nb_q;
						emit_db     = db_q;
						state_d     = S_IDLE;
					end else begin
						pn_d      = rsp.lo;
						req.start = 1'b1;
						req.op    = OP_MUL;
						req.a     = ld_q;
						req.b     = rd_q;
						state_d   = S_M2;
					end
				end
			end
			S_M2: begin
				if (rsp.done) begin
					pd_d = rsp.lo;
					priority if (rsp.hi != '0) begin
						emit        = 1'b1;
						emit_status = ST_CAPACITY;
						emit_nb     = nb_q;
						emit_db     = db_q;
						state_d     = S_IDLE;
					end else if (pn_q == '0 || rsp.lo == '0 || pn_q >= rsp.lo) begin
						emit        = 1'b1;
						emit_status = ST_INVALID;
						state_d     = S_IDLE;
					end else begin
						req.start = 1'b1;
						req.op    = OP_GCD;
						req.a     = pn_q;
						req.b     = rsp.lo;
						state_d   = S_G3;
					end
				end
			end
			S_G3: begin
				if (rsp.done) begin
					g_d       = rsp.lo;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = pn_q;
					req.b     = rsp.lo;
					state_d   = S_D3A;
				end
			end
			S_D3A: begin
				if (rsp.done) begin
					pn_d      = rsp.lo;
					req.start = 1'b1;
					req.op    = OP_DIV;
					req.a     = pd_q;
					req.b     = g_q;
					state_d   = S_D3B;
				end
			end
			S_D3B: begin
				if (rsp.done) begin
					emit        = 1'b1;
					emit_status = ST_OK;
					emit_num    = pn_q;
					emit_den    = rsp.lo;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs come straight from registers.
	always_comb begin
		busy           = (state_q != S_IDLE);
		done           = done_q;
		status         = status_q;
		prod_num       = onum_q;
		prod_den       = oden_q;
		num_bits_bound = onb_q;
		den_bits_bound = odb_q;
	end

endmodule
